### rtl/pip_pkg.sv
package pip_pkg;

    // fixed field widths
    localparam int COORD_WIDTH  = 32;
    localparam int COUNT_WIDTH  = 7;
    localparam int INDEX_WIDTH  = 6;
    localparam int MAX_VERTICES = 64;

    // registers from an edge entering the edge unit to its parity update being visible
    localparam int EDGE_LATENCY = 3;

    // item opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // register index (paddr / 4)
    localparam logic REG_VERTEX_COUNT = 1'b0;

    typedef struct packed {
        logic wr;
        logic shift;
    } t_cell_ctl;

    typedef struct packed {
        logic                          valid;
        logic signed [COORD_WIDTH-1:0] xi;
        logic signed [COORD_WIDTH-1:0] yi;
        logic signed [COORD_WIDTH-1:0] xj;
        logic signed [COORD_WIDTH-1:0] yj;
    } t_edge;

endpackage

### rtl/point_in_polygon_test.sv
// a vertex write item is taken while idle; a query item, once accepted, goes through one full
// turn of the vertex ring, the closing edge, the drain of the edge-unit pipeline and the result
// load, which waits for the result register to free up; no new item is taken until the result
// is loaded, and the vertex ring passes one vertex per cycle to the single edge unit
// reset (synchronous, active low): vertex_count clears to zero, control goes idle, the output
// register empties; vertex slots are not cleared and hold nothing until written
module point_in_polygon_test #(
    parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input item channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic                                   i_opcode,
    input  logic [pip_pkg::INDEX_WIDTH-1:0]        i_vertex_index,
    input  logic signed [pip_pkg::COORD_WIDTH-1:0] i_coord_x,
    input  logic signed [pip_pkg::COORD_WIDTH-1:0] i_coord_y,
    // result item channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic                                   o_inside_res,
    // register port
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [2:0]                             paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);

    localparam int CW     = pip_pkg::COORD_WIDTH;
    localparam int STEP_W = $clog2(MAX_VERTICES);
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int CMP_W  = (CNT_W > pip_pkg::COUNT_WIDTH) ? CNT_W : pip_pkg::COUNT_WIDTH;
    localparam int DRN_W  = $clog2(pip_pkg::EDGE_LATENCY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_CLOSE,
        S_DRAIN,
        S_FINISH
    } t_state;

    // ---------------------------------------------------------------- register port
    logic [pip_pkg::COUNT_WIDTH-1:0] r_count;
    logic                            w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == pip_pkg::REG_VERTEX_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_cfg_wr) begin
            r_count <= pwdata[pip_pkg::COUNT_WIDTH-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == pip_pkg::REG_VERTEX_COUNT) begin
            prdata = 32'(r_count);
        end
    end

    // vertices in use, clamped to the ring length
    logic [CMP_W-1:0] w_count_ext;
    logic [CMP_W-1:0] w_n;

    assign w_count_ext = CMP_W'(r_count);
    assign w_n = (w_count_ext > CMP_W'(MAX_VERTICES)) ? CMP_W'(MAX_VERTICES) : w_count_ext;

    // ---------------------------------------------------------------- control
    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [DRN_W-1:0]    r_drain, n_drain;
    logic                r_out_valid, n_out_valid;
    logic                r_out_res, n_out_res;
    logic signed [CW-1:0] r_qx, r_qy;
    logic signed [CW-1:0] r_prev_x, r_prev_y;
    logic signed [CW-1:0] r_first_x, r_first_y;
    logic signed [CW-1:0] r_last_x, r_last_y;

    logic                 w_in_acc;
    logic                 w_query_acc;
    logic                 w_write_acc;
    logic                 w_load_out;
    logic [CMP_W-1:0]     w_step_ext;
    logic                 w_clear;
    logic                 w_parity;
    pip_pkg::t_edge       w_edge;
    logic signed [CW-1:0] w_tap_x, w_tap_y;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_query_acc = w_in_acc && (i_opcode == pip_pkg::OP_QUERY);
    assign w_write_acc = w_in_acc && (i_opcode == pip_pkg::OP_WRITE);
    assign w_step_ext  = CMP_W'(r_step);
    assign w_clear     = w_query_acc;
    // the result register frees up when its item is taken
    assign w_load_out  = (r_state == S_FINISH) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_drain     = r_drain;
        n_out_valid = r_out_valid;
        n_out_res   = r_out_res;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_query_acc) begin
                    n_state = S_RUN;
                    n_step  = '0;
                end
            end
            S_RUN: begin
                // the ring needs a full turn to bring every slot back home
                if (r_step == STEP_W'(MAX_VERTICES - 1)) begin
                    n_state = S_CLOSE;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_CLOSE: begin
                n_state = S_DRAIN;
                n_drain = DRN_W'(pip_pkg::EDGE_LATENCY - 1);
            end
            S_DRAIN: begin
                if (r_drain == DRN_W'(1)) begin
                    n_state = S_FINISH;
                end else begin
                    n_drain = r_drain - 1'b1;
                end
            end
            S_FINISH: begin
                if (w_load_out) begin
                    n_out_valid = 1'b1;
                    n_out_res   = w_parity;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_drain     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_drain     <= n_drain;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers: query point, neighbour vertices seen at the ring tap
    always_ff @(posedge i_clk) begin
        r_out_res <= n_out_res;
        if (w_query_acc) begin
            r_qx <= i_coord_x;
            r_qy <= i_coord_y;
        end
        if (r_state == S_RUN) begin
            r_prev_x <= w_tap_x;
            r_prev_y <= w_tap_y;
            if (r_step == '0) begin
                r_first_x <= w_tap_x;
                r_first_y <= w_tap_y;
            end
            if ((w_n != '0) && (w_step_ext == (w_n - 1'b1))) begin
                r_last_x <= w_tap_x;
                r_last_y <= w_tap_y;
            end
        end
    end

    // edge feed: vertex k-1 to k while the ring turns, then last to first
    always_comb begin
        w_edge.valid = 1'b0;
        w_edge.xi    = w_tap_x;
        w_edge.yi    = w_tap_y;
        w_edge.xj    = r_prev_x;
        w_edge.yj    = r_prev_y;
        case (r_state)
            S_RUN: begin
                w_edge.valid = (r_step != '0) && (w_step_ext < w_n);
            end
            S_CLOSE: begin
                w_edge.valid = (w_n != '0);
                w_edge.xi    = r_first_x;
                w_edge.yi    = r_first_y;
                w_edge.xj    = r_last_x;
                w_edge.yj    = r_last_y;
            end
            default: begin
                w_edge.valid = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------- vertex ring
    // slot 0 is the tap; each turn step moves every vertex one slot down
    logic signed [CW-1:0] w_x [MAX_VERTICES];
    logic signed [CW-1:0] w_y [MAX_VERTICES];

    assign w_tap_x = w_x[0];
    assign w_tap_y = w_y[0];

    for (genvar c = 0; c < MAX_VERTICES; c++) begin : g_cell
        localparam logic [31:0] CELL_ID = c;
        localparam int NBR = (c + 1) % MAX_VERTICES;
        pip_pkg::t_cell_ctl w_ctl;

        // writes beyond the ring match no slot and fall away
        assign w_ctl.wr    = w_write_acc && (32'(i_vertex_index) == CELL_ID);
        assign w_ctl.shift = (r_state == S_RUN);

        pip_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_wr_x  (i_coord_x),
            .i_wr_y  (i_coord_y),
            .i_nbr_x (w_x[NBR]),
            .i_nbr_y (w_y[NBR]),
            .o_x     (w_x[c]),
            .o_y     (w_y[c])
        );
    end

    // ---------------------------------------------------------------- edge unit
    pip_edge u_edge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (w_clear),
        .i_edge   (w_edge),
        .i_qx     (r_qx),
        .i_qy     (r_qy),
        .o_parity (w_parity)
    );

    assign o_out_valid  = r_out_valid;
    assign o_inside_res = r_out_res;

`ifndef NO_ASSERTIONS
    // an accepted query starts a turn of the ring from slot zero
    a_query_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_query_acc |=> (r_state == S_RUN) && (r_step == '0))
        else $error("query did not start the ring turn");

    // the turn ends after exactly one pass over the ring
    a_turn_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) && (r_step == STEP_W'(MAX_VERTICES - 1)) |=> (r_state == S_CLOSE))
        else $error("ring turn did not end on the last slot");

    // no edge reaches the edge unit while items are being taken
    a_no_edge_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_edge.valid)
        else $error("edge issued while idle");

    // an empty polygon always reports outside
    a_empty_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out && (w_n == '0) |=> o_out_valid && !o_inside_res)
        else $error("empty polygon reported inside");
`endif

endmodule

### rtl/pip_cell.sv
module pip_cell (
    input  logic                                  i_clk,
    input  pip_pkg::t_cell_ctl                    i_ctl,
    input  logic signed [pip_pkg::COORD_WIDTH-1:0] i_wr_x,
    input  logic signed [pip_pkg::COORD_WIDTH-1:0] i_wr_y,
    input  logic signed [pip_pkg::COORD_WIDTH-1:0] i_nbr_x,
    input  logic signed [pip_pkg::COORD_WIDTH-1:0] i_nbr_y,
    output logic signed [pip_pkg::COORD_WIDTH-1:0] o_x,
    output logic signed [pip_pkg::COORD_WIDTH-1:0] o_y
);

    logic signed [pip_pkg::COORD_WIDTH-1:0] r_x;
    logic signed [pip_pkg::COORD_WIDTH-1:0] r_y;

    // vertex slot: loaded by a write item, passed on by one place per rotation step
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_x <= i_wr_x;
            r_y <= i_wr_y;
        end else if (i_ctl.shift) begin
            r_x <= i_nbr_x;
            r_y <= i_nbr_y;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;

endmodule

### rtl/pip_edge.sv
module pip_edge (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_clear,
    input  pip_pkg::t_edge                        i_edge,
    input  logic signed [pip_pkg::COORD_WIDTH-1:0] i_qx,
    input  logic signed [pip_pkg::COORD_WIDTH-1:0] i_qy,
    output logic                                  o_parity
);

    localparam int CW = pip_pkg::COORD_WIDTH;
    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;

    logic signed [CW-1:0] w_xi, w_yi, w_xj, w_yj;
    logic signed [DW-1:0] w_dy, w_dx, w_px, w_py;
    logic                 w_span;

    logic                 r_v1, n_v1;
    logic signed [DW-1:0] r_a, r_b, r_c, r_d;
    logic signed [DW-1:0] n_a, n_b, n_c, n_d;
    logic                 r_v2;
    logic signed [PW-1:0] r_p1, r_p2;
    logic signed [PW-1:0] n_p1, n_p2;
    logic                 r_parity, n_parity;

    assign w_xi = $signed(i_edge.xi);
    assign w_yi = $signed(i_edge.yi);
    assign w_xj = $signed(i_edge.xj);
    assign w_yj = $signed(i_edge.yj);

    // stage 1: half-open span test and differences
    always_comb begin
        w_span = ((w_yi <= i_qy) && (i_qy < w_yj)) || ((w_yj <= i_qy) && (i_qy < w_yi));
        w_dy   = DW'(w_yj) - DW'(w_yi);
        w_dx   = DW'(w_xj) - DW'(w_xi);
        w_px   = DW'(i_qx) - DW'(w_xi);
        w_py   = DW'(i_qy) - DW'(w_yi);
        n_v1   = i_edge.valid && w_span;
        // swap the sides of the compare when dy is not positive
        if (w_dy > 0) begin
            n_a = w_px;
            n_b = w_dy;
            n_c = w_dx;
            n_d = w_py;
        end else begin
            n_a = w_dx;
            n_b = w_py;
            n_c = w_px;
            n_d = w_dy;
        end
    end

    // stage 2: the two exact products
    always_comb begin
        n_p1 = PW'(r_a) * PW'(r_b);
        n_p2 = PW'(r_c) * PW'(r_d);
    end

    // stage 3: right-of test toggles the parity
    always_comb begin
        n_parity = r_parity;
        if (i_clear) begin
            n_parity = 1'b0;
        end else if (r_v2 && (r_p1 > r_p2)) begin
            n_parity = ~r_parity;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_parity <= 1'b0;
        end else begin
            r_v1     <= n_v1;
            r_v2     <= r_v1;
            r_parity <= n_parity;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a  <= n_a;
        r_b  <= n_b;
        r_c  <= n_c;
        r_d  <= n_d;
        r_p1 <= n_p1;
        r_p2 <= n_p2;
    end

    assign o_parity = r_parity;

endmodule

### tb/testbench.sv
module testbench;

    // field widths and codes shared with the block
    localparam int   COORD_WIDTH      = pip_pkg::COORD_WIDTH;
    localparam int   COUNT_WIDTH      = pip_pkg::COUNT_WIDTH;
    localparam int   INDEX_WIDTH      = pip_pkg::INDEX_WIDTH;
    localparam int   MAX_VERTICES     = pip_pkg::MAX_VERTICES;
    localparam logic OP_WRITE         = pip_pkg::OP_WRITE;
    localparam logic OP_QUERY         = pip_pkg::OP_QUERY;
    localparam logic REG_VERTEX_COUNT = pip_pkg::REG_VERTEX_COUNT;

    // coordinate extremes and a few run-wide constants
    localparam logic signed [COORD_WIDTH-1:0] COORD_LO = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam logic signed [COORD_WIDTH-1:0] COORD_HI = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam int PREDICTED    = -1;                 // no hand-typed answer for this row
    localparam int SETTLE_SPAN  = MAX_VERTICES + 8;   // one full ring turn plus margin
    localparam int TARGET_ITEMS = 650;

    typedef enum {STEP_ITEM, STEP_COUNT} t_step_kind;

    // one row of the directed table; a count row carries the new count in x
    typedef struct {
        t_step_kind                    kind;
        logic                          op;
        logic [INDEX_WIDTH-1:0]        idx;
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        int                            res;
    } t_step;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_ready;
    logic                          i_opcode;
    logic [INDEX_WIDTH-1:0]        i_vertex_index;
    logic signed [COORD_WIDTH-1:0] i_coord_x;
    logic signed [COORD_WIDTH-1:0] i_coord_y;
    logic                          o_out_valid;
    logic                          i_out_ready;
    logic                          o_inside_res;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [2:0]                    paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;

    // own copy of the geofence: vertex slots and the count register
    logic signed [COORD_WIDTH-1:0] fence_x [MAX_VERTICES];
    logic signed [COORD_WIDTH-1:0] fence_y [MAX_VERTICES];
    logic [COUNT_WIDTH-1:0]        fence_count;

    // answers still owed by the block, oldest first
    logic inside_expected [$];

    int   fail_count;
    int   items_sent;
    bit   steady;        // when set, neither side inserts gaps
    int   ready_hold;
    logic inside_want;

    point_in_polygon_test u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_vertex_index (i_vertex_index),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_inside_res   (o_inside_res),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // 10 time unit clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // even-odd ray cast over the edges in use; the right-of test is done by
    // exact cross-multiplication at 68 bits, so nothing can overflow
    function automatic logic point_inside(input logic signed [COORD_WIDTH-1:0] px,
                                          input logic signed [COORD_WIDTH-1:0] py);
        int                            n;
        int                            j;
        logic                          parity;
        logic                          in_span;
        logic signed [COORD_WIDTH-1:0] xi, yi, xj, yj;
        logic signed [COORD_WIDTH+1:0] dx, dy, ox, oy;
        logic signed [2*COORD_WIDTH+3:0] lhs, rhs;
        n = (fence_count > MAX_VERTICES) ? MAX_VERTICES : int'(fence_count);
        parity = 1'b0;
        if (n == 0) begin
            return 1'b0;
        end
        j = n - 1;
        for (int i = 0; i < n; i++) begin
            xi = fence_x[i];
            yi = fence_y[i];
            xj = fence_x[j];
            yj = fence_y[j];
            // half-open span: the lower end counts, the upper end does not
            in_span = (yi <= py && py < yj) || (yj <= py && py < yi);
            if (in_span) begin
                dy = yj - yi;
                dx = xj - xi;
                ox = px - xi;
                oy = py - yi;
                // the comparison flips when the edge runs downwards
                if (dy > 0) begin
                    lhs = ox * dy;
                    rhs = dx * oy;
                end else begin
                    lhs = dx * oy;
                    rhs = ox * dy;
                end
                if (lhs > rhs) begin
                    parity = ~parity;
                end
            end
            j = i;
        end
        return parity;
    endfunction

    // gap length for either side: mostly none, some short, a few long
    function automatic int pause_len();
        int r;
        if (steady) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    // coordinate at one of four scales; the tiny scale forces ties and
    // horizontal edges, the full scale reaches every bit
    function automatic logic signed [COORD_WIDTH-1:0] pick_coord(input int scale);
        case (scale)
            0:       return $signed(32'($urandom_range(0, 16))) - 32'sd8;
            1:       return $signed(32'($urandom_range(0, 2000))) - 32'sd1000;
            2:       return $signed($urandom) >>> 10;
            default: return $signed($urandom);
        endcase
    endfunction

    function automatic t_step row(input t_step_kind kind, input logic op, input int idx,
                                  input logic signed [COORD_WIDTH-1:0] x,
                                  input logic signed [COORD_WIDTH-1:0] y, input int res);
        t_step s;
        s.kind = kind;
        s.op   = op;
        s.idx  = idx[INDEX_WIDTH-1:0];
        s.x    = x;
        s.y    = y;
        s.res  = res;
        return s;
    endfunction

    // offer one item, wait for the handshake, then update the fence copy or
    // record the answer owed for a query
    task automatic send_item(input logic op, input logic [INDEX_WIDTH-1:0] idx,
                             input logic signed [COORD_WIDTH-1:0] x,
                             input logic signed [COORD_WIDTH-1:0] y, input int pinned);
        int   gap;
        logic answer;
        gap = pause_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_opcode       <= op;
        i_vertex_index <= idx;
        i_coord_x      <= x;
        i_coord_y      <= y;
        do @(posedge i_clk); while (!o_in_ready);
        // item taken at this edge
        if (op == OP_WRITE) begin
            fence_x[idx] = x;
            fence_y[idx] = y;
        end else begin
            answer = point_inside(x, y);
            if (pinned != PREDICTED) begin
                answer = pinned[0];
            end
            inside_expected.push_back(answer);
        end
        items_sent++;
    endtask

    // stop sending and wait until every owed answer is in; with_tail adds a ring
    // turn plus margin so a trailing vertex write has surely landed
    task automatic settle(input bit with_tail);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (inside_expected.size() != 0) begin
            @(posedge i_clk);
        end
        if (with_tail) begin
            repeat (SETTLE_SPAN) @(posedge i_clk);
        end
    endtask

    // apb write of the vertex count, then a read back of the same register
    task automatic set_vertex_count(input logic [COUNT_WIDTH-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_VERTEX_COUNT, 2'b00};
        pwdata  <= {{(32-COUNT_WIDTH){1'b0}}, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        fence_count = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {{(32-COUNT_WIDTH){1'b0}}, value}) begin
            $display("%0t: vertex_count read back, expected %0d, got %0d",
                     $time, value, prdata);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // one random phase: new count, a fresh polygon in the slots in use, then
    // mostly queries with a sprinkling of vertex rewrites
    task automatic run_phase(input int count);
        int                            n;
        int                            scale;
        int                            extra;
        int                            r;
        int                            v;
        bit                            backwards;
        logic signed [COORD_WIDTH-1:0] qx, qy;
        settle(1'b1);
        set_vertex_count(count[COUNT_WIDTH-1:0]);
        steady    = ($urandom_range(0, 3) == 0);
        scale     = $urandom_range(0, 3);
        backwards = $urandom_range(0, 1);
        n = (count > MAX_VERTICES) ? MAX_VERTICES : count;
        for (int k = 0; k < n; k++) begin
            v = backwards ? n - 1 - k : k;
            send_item(OP_WRITE, v[INDEX_WIDTH-1:0], pick_coord(scale), pick_coord(scale),
                      PREDICTED);
        end
        extra = $urandom_range(15, 35);
        for (int k = 0; k < extra; k++) begin
            // now and then hold off until the block has answered everything
            if ($urandom_range(0, 39) == 0) begin
                settle(1'b0);
            end
            r = $urandom_range(0, 99);
            if (r < 12) begin
                send_item(OP_WRITE, INDEX_WIDTH'($urandom), pick_coord(scale),
                          pick_coord(scale), PREDICTED);
            end else begin
                if (r < 62 || n == 0) begin
                    qx = pick_coord(scale);
                    qy = pick_coord(scale);
                end else if (r < 80) begin
                    // on or level with a vertex: exercises the span ends
                    qx = fence_x[$urandom_range(0, n - 1)];
                    qy = fence_y[$urandom_range(0, n - 1)];
                end else if (r < 92) begin
                    qx = $signed($urandom);
                    qy = $signed($urandom);
                end else begin
                    case ($urandom_range(0, 3))
                        0:       qx = COORD_LO;
                        1:       qx = COORD_HI;
                        2:       qx = '0;
                        default: qx = '1;
                    endcase
                    case ($urandom_range(0, 3))
                        0:       qy = COORD_LO;
                        1:       qy = COORD_HI;
                        2:       qy = '0;
                        default: qy = '1;
                    endcase
                end
                // index is ignored by a query, so it gets random bits
                send_item(OP_QUERY, INDEX_WIDTH'($urandom), qx, qy, PREDICTED);
            end
        end
    endtask

    // result side: random stalls on ready, every result checked in order
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (inside_expected.size() == 0) begin
                $display("%0t: inside_res with nothing owed, expected none, got %0b",
                         $time, o_inside_res);
                fail_count++;
            end else begin
                inside_want = inside_expected.pop_front();
                if (o_inside_res !== inside_want) begin
                    $display("%0t: inside_res mismatch, expected %0b, got %0b",
                             $time, inside_want, o_inside_res);
                    fail_count++;
                end
            end
        end
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (i_out_ready) begin
            ready_hold <= pause_len();
            if (pause_len() > 0) begin
                i_out_ready <= 1'b0;
            end
        end else begin
            i_out_ready <= 1'b1;
            ready_hold  <= $urandom_range(0, 6);
        end
    end

    // directed table, then random phases
    initial begin
        t_step plan [$];
        int    first_counts [8] = '{0, 3, 64, 127, 1, 2, 65, 4};
        int    phase;

        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_opcode       = OP_WRITE;
        i_vertex_index = '0;
        i_coord_x      = '0;
        i_coord_y      = '0;
        i_out_ready    = 1'b1;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        fail_count     = 0;
        items_sent     = 0;
        steady         = 1'b0;
        ready_hold     = 0;
        fence_count    = '0;
        for (int k = 0; k < MAX_VERTICES; k++) begin
            fence_x[k] = '0;
            fence_y[k] = '0;
        end

        // zero count after reset: always outside
        plan.push_back(row(STEP_ITEM, OP_QUERY, 0, '0, '0, 0));
        plan.push_back(row(STEP_ITEM, OP_QUERY, 63, COORD_LO, COORD_HI, 0));
        // square spanning the whole coordinate range, plus the top slot
        plan.push_back(row(STEP_ITEM, OP_WRITE, 0, COORD_LO, COORD_LO, PREDICTED));
        plan.push_back(row(STEP_ITEM, OP_WRITE, 1, COORD_HI, COORD_LO, PREDICTED));
        plan.push_back(row(STEP_ITEM, OP_WRITE, 2, COORD_HI, COORD_HI, PREDICTED));
        plan.push_back(row(STEP_ITEM, OP_WRITE, 3, COORD_LO, COORD_HI, PREDICTED));
        plan.push_back(row(STEP_ITEM, OP_WRITE, 63, COORD_HI, COORD_LO, PREDICTED));
        plan.push_back(row(STEP_COUNT, OP_WRITE, 0, 4, '0, PREDICTED));
        // centre of the full-range square is plainly inside
        plan.push_back(row(STEP_ITEM, OP_QUERY, 0, '0, '0, 1));
        // on each side and corner: half-open span and strict right-of decide
        plan.push_back(row(STEP_ITEM, OP_QUERY, 0, COORD_LO, '0, PREDICTED));
        plan.push_back(row(STEP_ITEM, OP_QUERY, 0, COORD_HI, '0, PREDICTED));
        plan.push_back(row(STEP_ITEM, OP_QUERY, 0, '0, COORD_LO, PREDICTED));
        plan.push_back(row(STEP_ITEM, OP_QUERY, 0, '0, COORD_HI, PREDICTED));
        plan.push_back(row(STEP_ITEM, OP_QUERY, 0, COORD_HI, COORD_HI, PREDICTED));
        plan.push_back(row(STEP_ITEM, OP_QUERY, 0, COORD_LO, COORD_LO, PREDICTED));
        // small right triangle
        plan.push_back(row(STEP_ITEM, OP_WRITE, 0, '0, '0, PREDICTED));
        plan.push_back(row(STEP_ITEM, OP_WRITE, 1, 100, '0, PREDICTED));
        plan.push_back(row(STEP_ITEM, OP_WRITE, 2, '0, 100, PREDICTED));
        plan.push_back(row(STEP_COUNT, OP_WRITE, 0, 3, '0, PREDICTED));
        plan.push_back(row(STEP_ITEM, OP_QUERY, 5, 10, 10, PREDICTED));
        plan.push_back(row(STEP_ITEM, OP_QUERY, 5, 50, 50, PREDICTED));
        plan.push_back(row(STEP_ITEM, OP_QUERY, 5, -1, 5, PREDICTED));
        plan.push_back(row(STEP_ITEM, OP_QUERY, 5, '0, '0, PREDICTED));
        // degenerate polygons: two vertices, then a single one
        plan.push_back(row(STEP_COUNT, OP_WRITE, 0, 2, '0, PREDICTED));
        plan.push_back(row(STEP_ITEM, OP_QUERY, 42, 50, '0, PREDICTED));
        plan.push_back(row(STEP_COUNT, OP_WRITE, 0, 1, '0, PREDICTED));
        plan.push_back(row(STEP_ITEM, OP_QUERY, 21, '0, '0, PREDICTED));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) begin
            if (plan[k].kind == STEP_COUNT) begin
                settle(1'b1);
                set_vertex_count(plan[k].x[COUNT_WIDTH-1:0]);
            end else begin
                send_item(plan[k].op, plan[k].idx, plan[k].x, plan[k].y, plan[k].res);
            end
        end

        // extremes of the count first, then mostly small polygons
        phase = 0;
        while (items_sent < TARGET_ITEMS) begin
            if (phase < 8) begin
                run_phase(first_counts[phase]);
            end else if ($urandom_range(0, 9) < 7) begin
                run_phase($urandom_range(3, 12));
            end else begin
                run_phase($urandom_range(0, 127));
            end
            phase++;
        end

        steady = 1'b0;
        settle(1'b1);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
